>>> hdl/kltk_pkg.sv
// Shared types, character codes and meta tag prefixes for the key log tokenizer.
`default_nettype none
package kltk_pkg;

   // Default depth of the tag buffer in bytes
   localparam int TOKEN_BUFFER_BYTES_DEF = 64;

   // Input beat: one raw log byte or an end of stream mark
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   // Output beat: one token byte
   typedef struct packed {
      logic [7:0] token_byte;
      logic       token_last;
      logic       token_chopped;
   } rsp_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_BRACKET
   } state_type;

   // Meta tag prefixes
   typedef enum logic [1:0] {
      META_KEYCOUNT,
      META_BEGIN,
      META_END
   } meta_sel_type;

   localparam int META_COUNT = 3;

   // Character codes
   localparam logic [7:0] CH_OPEN     = 8'h5B;
   localparam logic [7:0] CH_CLOSE    = 8'h5D;
   localparam logic [7:0] CH_NEWLINE  = 8'h0A;
   localparam logic [7:0] CH_PRINT_LO = 8'h20;
   localparam logic [7:0] CH_PRINT_HI = 8'h7E;

   localparam int KEYCOUNT_LEN = 10;
   localparam int BEGIN_LEN    = 18;
   localparam int END_LEN      = 16;
   localparam logic [8*KEYCOUNT_LEN-1:0] KEYCOUNT_STR = "[keycount ";
   localparam logic [8*BEGIN_LEN-1:0]    BEGIN_STR    = "[Keylogging begin]";
   localparam logic [8*END_LEN-1:0]      END_STR      = "[Keylogging end]";

   // Length of a meta prefix
   function automatic logic [7:0] meta_len(input meta_sel_type sel);
      logic [7:0] len;
      unique case (sel)
         META_KEYCOUNT: len = 8'(KEYCOUNT_LEN);
         META_BEGIN:    len = 8'(BEGIN_LEN);
         META_END:      len = 8'(END_LEN);
         default:       len = 8'hFF;
      endcase
      return len;
   endfunction

   // True if byte c at tag position pos still agrees with the prefix
   // (positions past the prefix always agree)
   function automatic logic meta_byte_ok(input meta_sel_type sel, input logic [7:0] pos,
                                         input logic [7:0] c);
      logic ok;
      ok = 1'b1;
      unique case (sel)
         META_KEYCOUNT:
            if (pos < 8'(KEYCOUNT_LEN))
               ok = (c == KEYCOUNT_STR[8*(KEYCOUNT_LEN-1-int'(pos)) +: 8]);
         META_BEGIN:
            if (pos < 8'(BEGIN_LEN))
               ok = (c == BEGIN_STR[8*(BEGIN_LEN-1-int'(pos)) +: 8]);
         META_END:
            if (pos < 8'(END_LEN))
               ok = (c == END_STR[8*(END_LEN-1-int'(pos)) +: 8]);
         default:
            ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage
`default_nettype wire

>>> hdl/kltk_buffer.sv
// Tag buffer memory: one write port, one registered read port.
`default_nettype none
module kltk_buffer #(
   parameter int BUF_BYTES = kltk_pkg::TOKEN_BUFFER_BYTES_DEF,
   parameter int AW        = $clog2(BUF_BYTES)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output      logic [7:0]    rd_data
);

   logic [7:0] buf_mem_ff [BUF_BYTES];
   logic [7:0] rd_data_ff;

   // Write when wr_en is set, read every cycle; read data is registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= buf_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hdl/kltk_ctrl.sv
// Tokenizer controller: byte classification, tag tracking, readout and output register.
`default_nettype none
module kltk_ctrl #(
   parameter int BUF_BYTES = kltk_pkg::TOKEN_BUFFER_BYTES_DEF,
   parameter int AW        = $clog2(BUF_BYTES)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire kltk_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      kltk_pkg::rsp_type rsp_data,
   output      logic              wr_en,
   output      logic [AW-1:0]     wr_addr,
   output      logic [7:0]        wr_data,
   output      logic [AW-1:0]     rd_addr,
   input  wire logic [7:0]        rd_data
);

   localparam logic [AW-1:0] LEN_MAX = AW'(BUF_BYTES - 1);

   kltk_pkg::state_type          state_ff, state_in;
   logic                         armed_ff, armed_in;
   logic                         inside_ff, inside_in;
   logic [AW-1:0]                len_ff, len_in;
   logic                         ovf_ff, ovf_in;
   logic [kltk_pkg::META_COUNT-1:0] match_ff, match_in;
   logic [AW-1:0]                rd_ptr_ff, rd_ptr_in;
   logic                         chop_ff, chop_in;
   logic                         brk_ff, brk_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   kltk_pkg::rsp_type            rsp_ff, rsp_in;

   logic                         accept;
   logic                         out_free;
   logic                         fin;
   logic                         fin_chop;
   logic                         fin_brk;
   logic                         is_meta;
   logic                         emit_last;
   logic [7:0]                   c;

   assign c         = req_data.data_byte;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == kltk_pkg::ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign emit_last = (rd_ptr_ff == len_ff - AW'(1));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kltk_pkg::ST_IDLE;
         armed_ff     <= 1'b0;
         inside_ff    <= 1'b0;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         armed_ff     <= armed_in;
         inside_ff    <= inside_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and readout registers
   always_ff @(posedge clock) begin
      match_ff  <= match_in;
      rd_ptr_ff <= rd_ptr_in;
      chop_ff   <= chop_in;
      brk_ff    <= brk_in;
      rsp_ff    <= rsp_in;
   end

   // Next state, buffer access and output beat
   always_comb begin
      state_in     = state_ff;
      armed_in     = armed_ff;
      inside_in    = inside_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      match_in     = match_ff;
      rd_ptr_in    = rd_ptr_ff;
      chop_in      = chop_ff;
      brk_in       = brk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = len_ff;
      wr_data      = c;
      rd_addr      = rd_ptr_ff;
      fin          = 1'b0;
      fin_chop     = 1'b0;
      fin_brk      = 1'b0;
      is_meta      = 1'b0;

      unique case (state_ff)
         kltk_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.end_of_stream) begin
                  // flush a pending tag chopped, then back to reset state
                  fin      = inside_ff;
                  fin_chop = 1'b1;
                  armed_in = 1'b0;
               end else if (inside_ff) begin
                  if (c == kltk_pkg::CH_OPEN) begin
                     armed_in = 1'b0;
                     fin      = 1'b1;
                     fin_chop = ovf_ff;
                     fin_brk  = 1'b1;
                  end else if (c == kltk_pkg::CH_NEWLINE) begin
                     armed_in = 1'b1;
                     fin      = 1'b1;
                     fin_chop = 1'b1;
                  end else begin
                     // store the byte or mark overflow
                     if (len_ff < LEN_MAX) begin
                        wr_en  = 1'b1;
                        len_in = len_ff + AW'(1);
                        for (int i = 0; i < kltk_pkg::META_COUNT; i++) begin
                           match_in[i] = match_ff[i] && kltk_pkg::meta_byte_ok(
                              kltk_pkg::meta_sel_type'(2'(i)), 8'(len_ff), c);
                        end
                     end else begin
                        ovf_in = 1'b1;
                     end
                     if (c == kltk_pkg::CH_CLOSE) begin
                        armed_in = 1'b0;
                        fin      = 1'b1;
                        fin_chop = ovf_in;
                     end
                  end
               end else if (c == kltk_pkg::CH_NEWLINE) begin
                  armed_in = 1'b1;
               end else if (c >= kltk_pkg::CH_PRINT_LO && c <= kltk_pkg::CH_PRINT_HI) begin
                  if (armed_ff && c == kltk_pkg::CH_OPEN) begin
                     // opening bracket is byte 0 and matches every prefix
                     inside_in = 1'b1;
                     wr_en     = 1'b1;
                     wr_addr   = '0;
                     len_in    = AW'(1);
                     ovf_in    = 1'b0;
                     match_in  = '1;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{token_byte: c, token_last: 1'b1, token_chopped: 1'b0};
                  end
               end
            end
         end

         kltk_pkg::ST_EMIT: begin
            // rd_data holds the byte at rd_ptr_ff
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{token_byte:    rd_data,
                                token_last:    emit_last,
                                token_chopped: emit_last && chop_ff};
               if (emit_last) begin
                  state_in = brk_ff ? kltk_pkg::ST_BRACKET : kltk_pkg::ST_IDLE;
               end else begin
                  rd_ptr_in = rd_ptr_ff + AW'(1);
                  rd_addr   = rd_ptr_ff + AW'(1);
               end
            end
         end

         kltk_pkg::ST_BRACKET: begin
            // the '[' that closed the tag is a token of its own
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{token_byte: kltk_pkg::CH_OPEN, token_last: 1'b1,
                                token_chopped: 1'b0};
               state_in     = kltk_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = kltk_pkg::ST_IDLE;
         end
      endcase

      // Tag finished: drop meta tags, otherwise start the readout at byte 0
      if (fin) begin
         for (int i = 0; i < kltk_pkg::META_COUNT; i++) begin
            if (match_in[i] && 8'(len_in) >= kltk_pkg::meta_len(
                   kltk_pkg::meta_sel_type'(2'(i)))) begin
               is_meta = 1'b1;
            end
         end
         inside_in = 1'b0;
         ovf_in    = 1'b0;
         brk_in    = fin_brk;
         chop_in   = fin_chop;
         if (!is_meta) begin
            state_in  = kltk_pkg::ST_EMIT;
            rd_ptr_in = '0;
            rd_addr   = '0;
         end else if (fin_brk) begin
            state_in = kltk_pkg::ST_BRACKET;
         end
      end
   end

`ifndef SYNTHESIS
   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kltk_pkg::ST_EMIT) |-> (rd_ptr_ff < len_ff))
      else $error("readout pointer beyond tag length");

   a_tag_not_empty: assert property (@(posedge clock) disable iff (reset)
      inside_ff |-> (len_ff != '0))
      else $error("open tag with no bytes");

   a_ovf_only_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (inside_ff && len_ff == LEN_MAX))
      else $error("overflow flag set on a tag that is not full");

   a_no_tag_in_readout: assert property (@(posedge clock) disable iff (reset)
      (state_ff != kltk_pkg::ST_IDLE) |-> !inside_ff)
      else $error("tag open during readout");

   a_readout_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kltk_pkg::ST_IDLE ##1 state_ff == kltk_pkg::ST_EMIT) |->
         (rd_ptr_ff == '0))
      else $error("readout did not start at byte zero");
`endif

endmodule
`default_nettype wire

>>> hdl/key_log_tokenizer_unit.sv
// Top level of the key log tokenizer: controller plus tag buffer memory.
`default_nettype none
// Splits a raw key log byte stream into tokens, one input beat per byte.
// A printable byte comes out as a one-byte token through the output
// register, so plain text flows at one byte per cycle while the output
// is not back-pressured. A bracketed tag after a newline is stored in the
// tag buffer memory; when it ends, input is held off while the tag is
// read back through the buffer's single registered read port, one byte per
// cycle while the output is not back-pressured, and while a '[' that
// closed it is sent as its own token. Meta tags are recognised while
// they are written and are dropped with no readout. No clearing pass is
// needed after reset.
module key_log_tokenizer_unit #(
   parameter int TOKEN_BUFFER_BYTES = kltk_pkg::TOKEN_BUFFER_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire kltk_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      kltk_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(TOKEN_BUFFER_BYTES);

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   // Byte handling, tag tracking and readout
   kltk_ctrl #(
      .BUF_BYTES (TOKEN_BUFFER_BYTES),
      .AW        (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // Tag storage
   kltk_buffer #(
      .BUF_BYTES (TOKEN_BUFFER_BYTES),
      .AW        (AW)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
`default_nettype wire

>>> tb/tb_key_log_tokenizer_unit.sv
// Self-checking testbench for the key log tokenizer: directed table, random runs, token checks.
`default_nettype none
module tb_key_log_tokenizer_unit;

   localparam int TAG_DEPTH   = kltk_pkg::TOKEN_BUFFER_BYTES_DEF;
   localparam int TEXT_BEATS  = 210;
   localparam int RUN_MIN     = 12;
   localparam int RUN_LIMIT   = 400000;
   localparam int HOLD_CYCLES = 300;

   // How a directed row is checked
   typedef enum {
      CHK_MODEL,
      CHK_SILENT,
      CHK_TOKEN
   } probe_check_type;

   typedef struct {
      logic [7:0]      data_byte;
      logic            eos;
      probe_check_type check;
      logic [7:0]      tok;
   } probe_row_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   kltk_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   kltk_pkg::rsp_type rsp_data;

   // Token beats still to come, oldest first, and those caused by the current beat
   kltk_pkg::rsp_type pending_tokens [$];
   kltk_pkg::rsp_type beat_tokens [$];

   // Tokenizer state as tracked by the testbench
   logic        armed;
   logic        in_tag;
   logic [7:0]  tag_bytes [TAG_DEPTH];
   int unsigned tag_len;
   logic        tag_chopped;

   int errors         = 0;
   int cycle_count    = 0;
   int counted_beats  = 0;
   bit quiet          = 1'b0;
   bit hold_request   = 1'b0;

   // Directed rows; plain results are typed in, tag results come from the predictor
   probe_row_type probes [25] = '{
      '{kltk_pkg::CH_PRINT_LO, 1'b0, CHK_TOKEN,  kltk_pkg::CH_PRINT_LO},  // lowest printable
      '{kltk_pkg::CH_PRINT_HI, 1'b0, CHK_TOKEN,  kltk_pkg::CH_PRINT_HI},  // highest printable
      '{8'h1F,                 1'b0, CHK_SILENT, 8'h00},
      '{8'h7F,                 1'b0, CHK_SILENT, 8'h00},
      '{8'h00,                 1'b0, CHK_SILENT, 8'h00},
      '{8'hFF,                 1'b0, CHK_SILENT, 8'h00},
      '{kltk_pkg::CH_OPEN,     1'b0, CHK_TOKEN,  kltk_pkg::CH_OPEN},  // bracket while unarmed
      '{kltk_pkg::CH_NEWLINE,  1'b0, CHK_SILENT, 8'h00},              // arms
      '{8'h78,                 1'b0, CHK_TOKEN,  8'h78},              // armed survives text
      '{kltk_pkg::CH_OPEN,     1'b0, CHK_SILENT, 8'h00},              // tag opens
      '{8'h00,                 1'b0, CHK_SILENT, 8'h00},              // NUL kept in tag
      '{kltk_pkg::CH_CLOSE,    1'b0, CHK_MODEL,  8'h00},
      '{kltk_pkg::CH_NEWLINE,  1'b0, CHK_SILENT, 8'h00},
      '{kltk_pkg::CH_OPEN,     1'b0, CHK_SILENT, 8'h00},
      '{8'h71,                 1'b0, CHK_SILENT, 8'h00},
      '{kltk_pkg::CH_OPEN,     1'b0, CHK_MODEL,  8'h00},              // tag closed by bracket
      '{kltk_pkg::CH_NEWLINE,  1'b0, CHK_SILENT, 8'h00},
      '{kltk_pkg::CH_OPEN,     1'b0, CHK_SILENT, 8'h00},
      '{8'h7A,                 1'b0, CHK_SILENT, 8'h00},
      '{kltk_pkg::CH_NEWLINE,  1'b0, CHK_MODEL,  8'h00},              // tag cut by newline
      '{kltk_pkg::CH_OPEN,     1'b0, CHK_SILENT, 8'h00},              // newline rearmed
      '{8'h6B,                 1'b0, CHK_SILENT, 8'h00},
      '{8'h00,                 1'b1, CHK_MODEL,  8'h00},              // end of stream flushes
      '{8'hFF,                 1'b1, CHK_SILENT, 8'h00},              // data ignored on end
      '{8'h41,                 1'b0, CHK_TOKEN,  8'h41}
   };

   key_log_tokenizer_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("tb_key_log_tokenizer_unit NOT OK");
         $finish;
      end
   end

   function automatic string meta_text(input kltk_pkg::meta_sel_type sel);
      case (sel)
         kltk_pkg::META_KEYCOUNT: return "[keycount ";
         kltk_pkg::META_BEGIN:    return "[Keylogging begin]";
         default:                 return "[Keylogging end]";
      endcase
   endfunction

   function automatic bit tag_is_meta();
      string text;
      bit    hit;
      hit = 1'b0;
      for (int m = 0; m < kltk_pkg::META_COUNT; m++) begin
         text = meta_text(kltk_pkg::meta_sel_type'(m));
         if (tag_len >= text.len()) begin
            hit = 1'b1;
            for (int i = 0; i < text.len(); i++)
               if (tag_bytes[i] != 8'(text[i])) hit = 1'b0;
            if (hit) return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void emit_token(input logic [7:0] b, input logic last, input logic chop);
      beat_tokens.push_back(kltk_pkg::rsp_type'{b, last, chop});
   endfunction

   // Close the open tag; meta tags vanish, others go out byte by byte
   function automatic void flush_tag(input logic chop);
      bit last;
      in_tag = 1'b0;
      if (!tag_is_meta()) begin
         for (int unsigned i = 0; i < tag_len; i++) begin
            last = (i + 1 == tag_len);
            emit_token(tag_bytes[i], last, last && chop);
         end
      end
      tag_len     = 0;
      tag_chopped = 1'b0;
   endfunction

   function automatic void clear_tokenizer();
      armed       = 1'b0;
      in_tag      = 1'b0;
      tag_len     = 0;
      tag_chopped = 1'b0;
   endfunction

   // Token beats caused by one input beat
   function automatic void tokenize_beat(input kltk_pkg::req_type r);
      logic [7:0] c;
      c = r.data_byte;
      beat_tokens.delete();
      if (r.end_of_stream) begin
         if (in_tag) flush_tag(1'b1);
         clear_tokenizer();
         return;
      end
      if (in_tag) begin
         if (c == kltk_pkg::CH_OPEN) begin
            armed = 1'b0;
            flush_tag(tag_chopped);
            emit_token(c, 1'b1, 1'b0);
            return;
         end
         if (c == kltk_pkg::CH_NEWLINE) begin
            armed = 1'b1;
            flush_tag(1'b1);
            return;
         end
         // bytes past the buffer are dropped, a dropped ']' still closes
         if (tag_len < TAG_DEPTH - 1) begin
            tag_bytes[tag_len] = c;
            tag_len++;
         end else begin
            tag_chopped = 1'b1;
         end
         if (c == kltk_pkg::CH_CLOSE) begin
            armed = 1'b0;
            flush_tag(tag_chopped);
         end
         return;
      end
      if (c == kltk_pkg::CH_NEWLINE) begin
         armed = 1'b1;
      end else if (c >= kltk_pkg::CH_PRINT_LO && c <= kltk_pkg::CH_PRINT_HI) begin
         if (armed && c == kltk_pkg::CH_OPEN) begin
            in_tag       = 1'b1;
            tag_bytes[0] = c;
            tag_len      = 1;
            tag_chopped  = 1'b0;
         end else begin
            emit_token(c, 1'b1, 1'b0);
         end
      end
   endfunction

   // Offer one beat; returns just after the edge that accepts it
   task automatic offer_beat(input kltk_pkg::req_type r, input probe_check_type check,
                             input logic [7:0] tok);
      if (!quiet && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (!quiet && $urandom_range(99) < 33);
      end
      counted_beats++;
      tokenize_beat(r);
      if (check == CHK_SILENT) begin
         beat_tokens.delete();
      end else if (check == CHK_TOKEN) begin
         beat_tokens.delete();
         beat_tokens.push_back(kltk_pkg::rsp_type'{tok, 1'b1, 1'b0});
      end
      foreach (beat_tokens[i]) pending_tokens.push_back(beat_tokens[i]);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_byte(input logic [7:0] c);
      offer_beat(kltk_pkg::req_type'{c, 1'b0}, CHK_MODEL, 8'h00);
   endtask

   function automatic logic [7:0] tag_body_byte();
      logic [7:0] c;
      do begin
         c = ($urandom_range(3) == 0) ?
                8'($urandom) :
                8'($urandom_range(kltk_pkg::CH_PRINT_HI, kltk_pkg::CH_PRINT_LO));
      end while (c == kltk_pkg::CH_OPEN || c == kltk_pkg::CH_CLOSE ||
                 c == kltk_pkg::CH_NEWLINE);
      return c;
   endfunction

   // Mostly a closing bracket; sometimes a bracket, newline, end of stream or nothing
   task automatic close_tag();
      int pick;
      pick = $urandom_range(9);
      if (pick < 6)
         send_byte(kltk_pkg::CH_CLOSE);
      else if (pick == 6)
         send_byte(kltk_pkg::CH_OPEN);
      else if (pick == 7)
         send_byte(kltk_pkg::CH_NEWLINE);
      else if (pick == 8)
         offer_beat(kltk_pkg::req_type'{8'($urandom), 1'b1}, CHK_MODEL, 8'h00);
   endtask

   task automatic text_run();
      repeat ($urandom_range(8, 1))
         send_byte(($urandom_range(4) == 0) ?
                      8'($urandom) :
                      8'($urandom_range(kltk_pkg::CH_PRINT_HI, kltk_pkg::CH_PRINT_LO)));
   endtask

   task automatic tag_run(input int lo, input int hi);
      send_byte(kltk_pkg::CH_NEWLINE);
      send_byte(kltk_pkg::CH_OPEN);
      repeat ($urandom_range(hi, lo)) send_byte(tag_body_byte());
      close_tag();
   endtask

   // Meta prefix: exact, cut short, or with one byte changed
   task automatic meta_run();
      logic [7:0] seq [$];
      logic [7:0] c;
      string      text;
      int         mode;
      int         pos;
      text = meta_text(kltk_pkg::meta_sel_type'($urandom_range(kltk_pkg::META_COUNT - 1)));
      for (int i = 0; i < text.len(); i++) seq.push_back(8'(text[i]));
      mode = $urandom_range(3);
      if (mode == 1) begin
         pos = $urandom_range(text.len() - 1, 1);
         while (seq.size() > pos) void'(seq.pop_back());
      end else if (mode == 2) begin
         pos = $urandom_range(text.len() - 1, 1);
         do c = tag_body_byte(); while (c == seq[pos]);
         seq[pos] = c;
      end
      send_byte(kltk_pkg::CH_NEWLINE);
      foreach (seq[i]) send_byte(seq[i]);
      if (seq[$] != kltk_pkg::CH_CLOSE) begin
         repeat ($urandom_range(4)) send_byte(tag_body_byte());
         close_tag();
      end
   endtask

   // Result side: random back-pressure, one long hold-off on request
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet || ($urandom_range(99) >= 33);
         end
      end
   end

   // Compare each accepted token beat with the oldest one pending
   always @(posedge clock) begin
      kltk_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_tokens.size() == 0) begin
            $error("unexpected token beat: byte %h last %b chopped %b",
                   rsp_data.token_byte, rsp_data.token_last, rsp_data.token_chopped);
            errors++;
         end else begin
            want = pending_tokens.pop_front();
            if (rsp_data.token_byte !== want.token_byte) begin
               $error("token_byte: expected %h, got %h", want.token_byte, rsp_data.token_byte);
               errors++;
            end
            if (rsp_data.token_last !== want.token_last) begin
               $error("token_last: expected %b, got %b", want.token_last, rsp_data.token_last);
               errors++;
            end
            if (rsp_data.token_chopped !== want.token_chopped) begin
               $error("token_chopped: expected %b, got %b",
                      want.token_chopped, rsp_data.token_chopped);
               errors++;
            end
         end
      end
   end

   initial begin : stimulus
      int runs;
      int pick;
      clear_tokenizer();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (probes[i])
         offer_beat(kltk_pkg::req_type'{probes[i].data_byte, probes[i].eos}, probes[i].check,
                    probes[i].tok);

      runs = 0;
      while (counted_beats < TEXT_BEATS || runs < RUN_MIN) begin
         quiet = (runs >= 6 && runs < 12);
         if (runs == 1) begin
            // long tag that may overflow, closing bracket may land past the buffer
            tag_run(TAG_DEPTH - 3, TAG_DEPTH + 11);
         end else if (runs == 3) begin
            // receiver holds off while text keeps coming
            hold_request = 1'b1;
            repeat (12)
               send_byte(8'($urandom_range(kltk_pkg::CH_PRINT_HI, kltk_pkg::CH_PRINT_LO)));
         end else if (runs == 5) begin
            // sender waits for the block to drain
            req_valid <= 1'b0;
            while (pending_tokens.size() != 0) @(posedge clock);
            @(posedge clock);
         end else begin
            pick = $urandom_range(99);
            if (pick < 25)
               text_run();
            else if (pick < 60)
               tag_run(0, 10);
            else if (pick < 80)
               meta_run();
            else if (pick < 84)
               tag_run(TAG_DEPTH - 10, TAG_DEPTH + 11);
            else if (pick < 92)
               repeat ($urandom_range(4, 1))
                  offer_beat(kltk_pkg::req_type'{8'($urandom), 1'($urandom_range(7) == 0)},
                             CHK_MODEL, 8'h00);
            else
               offer_beat(kltk_pkg::req_type'{8'($urandom), 1'b1}, CHK_MODEL, 8'h00);
         end
         runs++;
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      // drain, then keep watching for stray token beats
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (TAG_DEPTH + 8) @(posedge clock);
      if (errors == 0)
         $display("tb_key_log_tokenizer_unit OK");
      else
         $display("tb_key_log_tokenizer_unit NOT OK");
      $finish;
   end

endmodule
`default_nettype wire
